// ===== rtl/core/hbsf_pkg.sv =====
// package for the histogram best split finder
// widths of the data fields, fixed point constants, sequencer states
// no dependencies
package hbsf_pkg;

    localparam int SUM_W      = 40;   // bin target sum
    localparam int TSUM_W     = 48;   // histogram target sum and running left sum
    localparam int LEAF_W     = 24;   // min_leaf_count register
    localparam int INDEX_W    = 17;   // signed best index
    localparam int GAIN_W     = 63;   // saturated gain
    localparam int FRAC_BITS  = 16;

    // magnitude of a 49-bit signed sum, split in two halves for the multiplier
    localparam int MAG_W      = TSUM_W + 1;
    localparam int MUL_LO_W   = 24;
    localparam int MUL_HI_W   = MAG_W - MUL_LO_W;
    localparam int PP_W       = 2 * MUL_HI_W;

    // square of the magnitude, whose even width suits two bits a cycle
    localparam int SQ_W       = 98;
    localparam int ACC_W      = SQ_W + 2;
    localparam int DIV_STEPS  = SQ_W / 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_MIN_LEAF = 1'b0;
    localparam logic [LEAF_W-1:0] LEAF_RESET = 24'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_SCORE
    } t_state;

    typedef enum logic [1:0] {
        TERM_LEFT,
        TERM_RIGHT,
        TERM_TOTAL
    } t_term;

    typedef enum logic [1:0] {
        MSTEP_LO_LO,
        MSTEP_LO_HI,
        MSTEP_HI_HI,
        MSTEP_LAST
    } t_mstep;

endpackage

// ===== rtl/core/hbsf_bin_if.sv =====
// bin channel: valid/ready handshake plus one histogram bin word
// depends on hbsf_pkg
interface hbsf_bin_if
    import hbsf_pkg::*;
#(
    parameter int COUNT_BITS = 24
) ();
    logic                     valid;
    logic                     ready;
    logic [COUNT_BITS-1:0]    bin_count;
    logic signed [SUM_W-1:0]  bin_sum;
    logic signed [TSUM_W-1:0] total_sum;
    logic [COUNT_BITS-1:0]    total_count;
    logic                     last_bin;

    modport source (
        output valid, bin_count, bin_sum, total_sum, total_count, last_bin,
        input  ready
    );
    modport sink (
        input  valid, bin_count, bin_sum, total_sum, total_count, last_bin,
        output ready
    );
endinterface

// ===== rtl/core/hbsf_split_if.sv =====
// split result channel: valid/ready handshake plus best index and gain
// depends on hbsf_pkg
interface hbsf_split_if
    import hbsf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [INDEX_W-1:0] best_index;
    logic [GAIN_W-1:0]         best_gain;

    modport source (output valid, best_index, best_gain, input ready);
    modport sink   (input valid, best_index, best_gain, output ready);
endinterface

// ===== rtl/core/histogram_best_split_finder_core.sv =====
// histogram best split finder, top level
// depends on hbsf_pkg, hbsf_bin_if, hbsf_split_if
//
// usage: bins of one feature histogram enter on i_bin in order, the last one
// marked by last_bin. each other bin updates the running left count and left sum and,
// when both sides meet min_leaf_count, scores gain sL^2/cL + sR^2/cR - T^2/N.
// the last bin loads best_index/best_gain into the output register o_split
// (in the cycle after that bin is taken) and clears the scan; other bins give no
// word. min_leaf_count is written over the apb port at address 0.
// work per bin: a bin that is not scored passes accept and may pass check; a
// scored bin passes accept, check and score, and each of the three
// square-over-count terms passes setup, the shared 25x25 multiplier, the
// shared radix-4 restoring divider and the gain accumulator.
// i_bin.ready is low while a bin is in work. a finished word waits in the
// output register; while it waits and o_split.ready is low no bin is taken,
// so a stalled receiver stalls the input once one word is pending.
// reset: min_leaf_count returns to 256, the scan clears, no word is pending.
module histogram_best_split_finder_core
    import hbsf_pkg::*;
#(
    parameter int MAX_BINS   = 65536,
    parameter int COUNT_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    hbsf_bin_if.sink               i_bin,
    hbsf_split_if.source           o_split,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int PB   = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int CB   = COUNT_BITS;
    localparam int LW   = (CB > LEAF_W) ? CB : LEAF_W;
    localparam logic [PB-1:0] POS_MAX = PB'(MAX_BINS - 1);

    // control state
    t_state              r_state, n_state;
    logic [LEAF_W-1:0]   r_min_leaf, n_min_leaf;
    logic [PB-1:0]       r_bin_pos, n_bin_pos;
    logic [CB-1:0]       r_left_count, n_left_count;
    logic [TSUM_W-1:0]   r_left_sum, n_left_sum;
    logic [GAIN_W-1:0]   r_top_gain, n_top_gain;
    logic [PB-1:0]       r_top_pos, n_top_pos;
    logic                r_top_valid, n_top_valid;
    logic                r_stopped, n_stopped;
    logic                r_out_valid, n_out_valid;
    t_term               r_term, n_term;
    t_mstep              r_step, n_step;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;

    // datapath
    logic [TSUM_W-1:0]   r_tsum, n_tsum;
    logic [CB-1:0]       r_tcnt, n_tcnt;
    logic [PB-1:0]       r_cur_pos, n_cur_pos;
    logic [CB-1:0]       r_rcnt, n_rcnt;
    logic [MAG_W-1:0]    r_rsum, n_rsum;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [CB-1:0]       r_div, n_div;
    logic [PP_W-1:0]     r_pp, n_pp;
    logic [SQ_W-1:0]     r_prod, n_prod;
    logic [CB-1:0]       r_rem, n_rem;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [INDEX_W-1:0]  r_out_index, n_out_index;
    logic [GAIN_W-1:0]   r_out_gain, n_out_gain;

    // combinational helpers
    logic                in_take;
    logic                cfg_write;
    logic [CB:0]         left_count_sum;
    logic [LEAF_W-1:0]   lim;
    logic                left_ok;
    logic                right_short;
    logic [CB-1:0]       rdiff;
    logic [MAG_W-1:0]    sel_s;
    logic [CB-1:0]       sel_c;
    logic [MAG_W-1:0]    sel_neg;
    logic [MUL_HI_W-1:0] mul_a, mul_b;
    logic [PP_W-1:0]     pp;
    logic [SQ_W-1:0]     pp_ext;
    logic [CB:0]         t1, t2, sub1, sub2;
    logic                ge1, ge2;
    logic [CB-1:0]       rem1, rem2;
    logic                gain_pos;
    logic                gain_sat;
    logic [GAIN_W-1:0]   gain;

    assign in_take   = i_bin.valid && i_bin.ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign i_bin.ready = (r_state == ST_IDLE) && (!r_out_valid || o_split.ready);

    assign o_split.valid      = r_out_valid;
    assign o_split.best_index = r_out_index;
    assign o_split.best_gain  = r_out_gain;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_MIN_LEAF)
                  ? APB_DATA_W'(r_min_leaf) : '0;

    // running left count, saturating
    assign left_count_sum = {1'b0, r_left_count} + {1'b0, i_bin.bin_count};

    // leaf limit checks, a limit of zero behaves as one
    assign lim         = (r_min_leaf == '0) ? LEAF_W'(1) : r_min_leaf;
    assign left_ok     = LW'(r_left_count) >= LW'(lim);
    assign rdiff       = r_tcnt - r_left_count;
    assign right_short = (r_left_count > r_tcnt) || (LW'(rdiff) < LW'(lim));

    // operand of the current term
    always_comb begin
        unique case (r_term)
            TERM_LEFT: begin
                sel_s = {r_left_sum[TSUM_W-1], r_left_sum};
                sel_c = r_left_count;
            end
            TERM_RIGHT: begin
                sel_s = r_rsum;
                sel_c = r_rcnt;
            end
            TERM_TOTAL: begin
                sel_s = {r_tsum[TSUM_W-1], r_tsum};
                sel_c = r_tcnt;
            end
            default: begin
                sel_s = '0;
                sel_c = r_tcnt;
            end
        endcase
    end
    assign sel_neg = ~sel_s + MAG_W'(1);

    // shared multiplier: mag = hi*2^24 + lo, square built from three products
    assign mul_a  = (r_step == MSTEP_HI_HI) ? r_mag[MAG_W-1:MUL_LO_W]
                                            : {1'b0, r_mag[MUL_LO_W-1:0]};
    assign mul_b  = (r_step == MSTEP_LO_LO) ? {1'b0, r_mag[MUL_LO_W-1:0]}
                                            : r_mag[MAG_W-1:MUL_LO_W];
    assign pp     = mul_a * mul_b;
    assign pp_ext = SQ_W'(r_pp);

    // divider, two restoring steps a cycle
    assign t1   = {r_rem, r_prod[SQ_W-1]};
    assign sub1 = t1 - {1'b0, r_div};
    assign ge1  = t1 >= {1'b0, r_div};
    assign rem1 = ge1 ? sub1[CB-1:0] : t1[CB-1:0];
    assign t2   = {rem1, r_prod[SQ_W-2]};
    assign sub2 = t2 - {1'b0, r_div};
    assign ge2  = t2 >= {1'b0, r_div};
    assign rem2 = ge2 ? sub2[CB-1:0] : t2[CB-1:0];

    // gain from the accumulated terms
    assign gain_pos = !r_acc[ACC_W-1] && (r_acc != '0);
    assign gain_sat = |r_acc[ACC_W-1:FRAC_BITS+GAIN_W];
    assign gain     = gain_sat ? '1 : r_acc[FRAC_BITS+GAIN_W-1:FRAC_BITS];

    always_comb begin
        n_state      = r_state;
        n_min_leaf   = r_min_leaf;
        n_bin_pos    = r_bin_pos;
        n_left_count = r_left_count;
        n_left_sum   = r_left_sum;
        n_top_gain   = r_top_gain;
        n_top_pos    = r_top_pos;
        n_top_valid  = r_top_valid;
        n_stopped    = r_stopped;
        n_out_valid  = r_out_valid;
        n_term       = r_term;
        n_step       = r_step;
        n_dcnt       = r_dcnt;
        n_tsum       = r_tsum;
        n_tcnt       = r_tcnt;
        n_cur_pos    = r_cur_pos;
        n_rcnt       = r_rcnt;
        n_rsum       = r_rsum;
        n_mag        = r_mag;
        n_div        = r_div;
        n_pp         = r_pp;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_acc        = r_acc;
        n_out_index  = r_out_index;
        n_out_gain   = r_out_gain;

        if (cfg_write && (paddr[APB_ADDR_W-1] == REG_MIN_LEAF)) begin
            n_min_leaf = pwdata[LEAF_W-1:0];
        end

        if (r_out_valid && o_split.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_bin.last_bin) begin
                        n_out_valid  = 1'b1;
                        n_out_index  = r_top_valid ? INDEX_W'(r_top_pos) : '1;
                        n_out_gain   = r_top_gain;
                        n_bin_pos    = '0;
                        n_left_count = '0;
                        n_left_sum   = '0;
                        n_top_gain   = '0;
                        n_top_pos    = '0;
                        n_top_valid  = 1'b0;
                        n_stopped    = 1'b0;
                    end else begin
                        n_left_count = left_count_sum[CB] ? '1 : left_count_sum[CB-1:0];
                        n_left_sum   = r_left_sum
                                     + {{(TSUM_W-SUM_W){i_bin.bin_sum[SUM_W-1]}},
                                        i_bin.bin_sum};
                        n_tsum       = i_bin.total_sum;
                        n_tcnt       = i_bin.total_count;
                        n_cur_pos    = r_bin_pos;
                        if (r_bin_pos != POS_MAX) begin
                            n_bin_pos = r_bin_pos + PB'(1);
                        end
                        if (!r_stopped && (r_bin_pos != POS_MAX)) begin
                            n_state = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (!left_ok) begin
                    n_state = ST_IDLE;
                end else if (right_short) begin
                    n_stopped = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_rcnt  = rdiff;
                    n_rsum  = {r_tsum[TSUM_W-1], r_tsum}
                            - {r_left_sum[TSUM_W-1], r_left_sum};
                    n_term  = TERM_LEFT;
                    n_acc   = '0;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_mag   = sel_s[MAG_W-1] ? sel_neg : sel_s;
                n_div   = sel_c;
                n_prod  = '0;
                n_step  = MSTEP_LO_LO;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_pp = pp;
                unique case (r_step)
                    MSTEP_LO_LO: begin
                        n_step = MSTEP_LO_HI;
                    end
                    MSTEP_LO_HI: begin
                        n_prod = r_prod + pp_ext;
                        n_step = MSTEP_HI_HI;
                    end
                    MSTEP_HI_HI: begin
                        // cross product counts twice: shift by 24 + 1
                        n_prod = r_prod + (pp_ext << (MUL_LO_W + 1));
                        n_step = MSTEP_LAST;
                    end
                    MSTEP_LAST: begin
                        n_prod  = r_prod + (pp_ext << (2 * MUL_LO_W));
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_state = ST_DIV;
                    end
                    default: begin
                        n_step = MSTEP_LO_LO;
                    end
                endcase
            end
            ST_DIV: begin
                // quotient bits shift in at the bottom as dividend bits leave the top
                n_prod = {r_prod[SQ_W-3:0], ge1, ge2};
                n_rem  = rem2;
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                unique case (r_term)
                    TERM_LEFT: begin
                        n_acc   = r_acc + ACC_W'(r_prod);
                        n_term  = TERM_RIGHT;
                        n_state = ST_SETUP;
                    end
                    TERM_RIGHT: begin
                        n_acc   = r_acc + ACC_W'(r_prod);
                        n_term  = TERM_TOTAL;
                        n_state = ST_SETUP;
                    end
                    TERM_TOTAL: begin
                        n_acc   = r_acc - ACC_W'(r_prod);
                        n_state = ST_SCORE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SCORE: begin
                // first strictly greatest gain wins
                if (gain_pos && (gain > r_top_gain)) begin
                    n_top_gain  = gain;
                    n_top_pos   = r_cur_pos;
                    n_top_valid = 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_leaf   <= LEAF_RESET;
            r_bin_pos    <= '0;
            r_left_count <= '0;
            r_left_sum   <= '0;
            r_top_gain   <= '0;
            r_top_pos    <= '0;
            r_top_valid  <= 1'b0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_term       <= TERM_LEFT;
            r_step       <= MSTEP_LO_LO;
            r_dcnt       <= '0;
        end else begin
            r_state      <= n_state;
            r_min_leaf   <= n_min_leaf;
            r_bin_pos    <= n_bin_pos;
            r_left_count <= n_left_count;
            r_left_sum   <= n_left_sum;
            r_top_gain   <= n_top_gain;
            r_top_pos    <= n_top_pos;
            r_top_valid  <= n_top_valid;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
            r_term       <= n_term;
            r_step       <= n_step;
            r_dcnt       <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsum      <= n_tsum;
        r_tcnt      <= n_tcnt;
        r_cur_pos   <= n_cur_pos;
        r_rcnt      <= n_rcnt;
        r_rsum      <= n_rsum;
        r_mag       <= n_mag;
        r_div       <= n_div;
        r_pp        <= n_pp;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_acc       <= n_acc;
        r_out_index <= n_out_index;
        r_out_gain  <= n_out_gain;
    end

endmodule
